>>> rtl/ede_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ede_pkg
// Shared constants and width helpers for the Elias delta encoder.
// ----------------------------------------------------------------------------
package ede_pkg;

    localparam int IN_WIDTH        = 32;
    localparam int BYTE_BITS       = 8;
    localparam int MSB_W           = $clog2(BYTE_BITS);
    localparam int VB_WIDTH        = 4;
    localparam int OUT_TDATA_W     = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Number of input bits that actually take part in the code.
    function automatic int eff_width(input int vw);
        return (vw < IN_WIDTH) ? vw : IN_WIDTH;
    endfunction

    // Width of the bit length of a value, 1 .. eff_width.
    function automatic int len_width(input int vw);
        return $clog2(eff_width(vw) + 1);
    endfunction

    // Longest code: gamma of the length plus the offset bits of the value.
    function automatic int code_bits(input int vw);
        return 2 * (len_width(vw) - 1) + eff_width(vw);
    endfunction

    function automatic int code_bytes(input int vw);
        return (code_bits(vw) + BYTE_BITS - 1) / BYTE_BITS;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ede_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ede_front
// Stages one and two: per-byte leading-one detect, then bit length, length
// of the length, and the value with its leading one removed.
// ----------------------------------------------------------------------------
module ede_front import ede_pkg::*; #(
    parameter int  VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int W           = eff_width(VALUE_WIDTH),
    localparam int LEN_W       = len_width(VALUE_WIDTH),
    localparam int LOL_W       = $clog2(LEN_W)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [IN_WIDTH-1:0] i_value,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_zero,
    output logic [LEN_W-1:0]         o_len,
    output logic [LOL_W-1:0]         o_lol,
    output logic [W-1:0]             o_off
);

    localparam int LANES = (W + BYTE_BITS - 1) / BYTE_BITS;
    localparam int PW    = LANES * BYTE_BITS;

    logic             w_ready1;
    logic             w_ready2;

    logic             r1_valid;
    logic [PW-1:0]    r1_val;
    logic [PW-1:0]    n1_val;
    logic             r1_nz  [LANES];
    logic             n1_nz  [LANES];
    logic [MSB_W-1:0] r1_msb [LANES];
    logic [MSB_W-1:0] n1_msb [LANES];

    logic             r2_valid;
    logic             r2_zero;
    logic             n2_found;
    logic [LEN_W-1:0] r2_len;
    logic [LEN_W-1:0] n2_len;
    logic [LOL_W-1:0] r2_lol;
    logic [LOL_W-1:0] n2_lol;
    logic [PW-1:0]    r2_off;
    logic [PW-1:0]    n2_off;

    assign w_ready2 = !r2_valid || i_ready;
    assign w_ready1 = !r1_valid || w_ready2;
    assign o_ready  = w_ready1;

    always_comb begin
        n1_val        = '0;
        n1_val[W-1:0] = i_value[W-1:0];
        for (int l = 0; l < LANES; l++) begin
            n1_nz[l]  = |n1_val[l*BYTE_BITS +: BYTE_BITS];
            n1_msb[l] = '0;
            for (int b = 0; b < BYTE_BITS; b++) begin
                if (n1_val[l*BYTE_BITS + b]) begin
                    n1_msb[l] = MSB_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_ready1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready1 && i_valid) begin
            r1_val <= n1_val;
            r1_nz  <= n1_nz;
            r1_msb <= n1_msb;
        end
    end

    // The highest nonzero byte lane sets the length and loses its leading one.
    always_comb begin
        n2_found = 1'b0;
        n2_len   = '0;
        n2_off   = r1_val;
        for (int l = LANES - 1; l >= 0; l--) begin
            if (!n2_found && r1_nz[l]) begin
                n2_found = 1'b1;
                n2_len   = LEN_W'(l * BYTE_BITS + int'(r1_msb[l]) + 1);
                n2_off[l*BYTE_BITS +: BYTE_BITS] = r1_val[l*BYTE_BITS +: BYTE_BITS]
                    & ~(BYTE_BITS'(1) << r1_msb[l]);
            end
        end
        n2_lol = '0;
        for (int b = 0; b < LEN_W; b++) begin
            if (n2_len[b]) begin
                n2_lol = LOL_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_ready2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready2 && r1_valid) begin
            r2_zero <= !n2_found;
            r2_len  <= n2_len;
            r2_lol  <= n2_lol;
            r2_off  <= n2_off;
        end
    end

    assign o_valid = r2_valid;
    assign o_zero  = r2_zero;
    assign o_len   = r2_len;
    assign o_lol   = r2_lol;
    assign o_off   = r2_off[W-1:0];

endmodule
`default_nettype wire

>>> rtl/ede_pack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ede_pack
// Stage three: assembles the full code word with its one padding, works
// out the byte count and the fill of the final byte, and flags a zero input.
// ----------------------------------------------------------------------------
module ede_pack import ede_pkg::*; #(
    parameter int  VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int W           = eff_width(VALUE_WIDTH),
    localparam int LEN_W       = len_width(VALUE_WIDTH),
    localparam int LOL_W       = $clog2(LEN_W),
    localparam int NB          = code_bytes(VALUE_WIDTH),
    localparam int CB          = NB * BYTE_BITS,
    localparam int CNT_W       = $clog2(NB + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_zero,
    input  wire logic [LEN_W-1:0] i_len,
    input  wire logic [LOL_W-1:0] i_lol,
    input  wire logic [W-1:0]     i_off,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [CB-1:0]         o_code,
    output logic [CNT_W-1:0]      o_nbytes,
    output logic [VB_WIDTH-1:0]   o_last_bits,
    output logic                  o_error
);

    localparam int TOT_W = $clog2(CB + 1);

    logic                w_ready;
    logic [CB-1:0]       w_ones;
    logic [CB-1:0]       w_lenf;
    logic [TOT_W-1:0]    w_total;

    logic                r_valid;
    logic [CB-1:0]       r_code;
    logic [CB-1:0]       n_code;
    logic [CNT_W-1:0]    r_nbytes;
    logic [CNT_W-1:0]    n_nbytes;
    logic [VB_WIDTH-1:0] r_last_bits;
    logic [VB_WIDTH-1:0] n_last_bits;
    logic                r_error;
    logic                n_error;

    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;

    // Layout from bit 0: lol ones, a zero, lol low bits of the length,
    // the offset bits of the value, then ones up to the byte boundary.
    always_comb begin
        w_ones  = (CB'(1) << i_lol) - CB'(1);
        w_lenf  = CB'(i_len) & w_ones;
        w_total = TOT_W'(2 * int'(i_lol) + int'(i_len));
        n_code  = w_ones
                | (w_lenf << (int'(i_lol) + 1))
                | (CB'(i_off) << (2 * int'(i_lol) + 1))
                | ({CB{1'b1}} << w_total);
        n_nbytes    = CNT_W'((int'(w_total) + BYTE_BITS - 1) / BYTE_BITS);
        n_last_bits = VB_WIDTH'(((int'(w_total) - 1) % BYTE_BITS) + 1);
        n_error     = 1'b0;
        if (i_zero) begin
            n_code      = '0;
            n_nbytes    = CNT_W'(1);
            n_last_bits = '0;
            n_error     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_code      <= n_code;
            r_nbytes    <= n_nbytes;
            r_last_bits <= n_last_bits;
            r_error     <= n_error;
        end
    end

    assign o_valid     = r_valid;
    assign o_code      = r_code;
    assign o_nbytes    = r_nbytes;
    assign o_last_bits = r_last_bits;
    assign o_error     = r_error;

endmodule
`default_nettype wire

>>> rtl/ede_serial.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ede_serial
// Output stage: shifts a packed code word out one byte per transaction.
// ----------------------------------------------------------------------------
module ede_serial import ede_pkg::*; #(
    parameter int  VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int NB          = code_bytes(VALUE_WIDTH),
    localparam int CB          = NB * BYTE_BITS,
    localparam int CNT_W       = $clog2(NB + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [CB-1:0]       i_code,
    input  wire logic [CNT_W-1:0]    i_nbytes,
    input  wire logic [VB_WIDTH-1:0] i_last_bits,
    input  wire logic                i_error,
    output logic                     o_tvalid,
    input  wire logic                i_tready,
    output logic [OUT_TDATA_W-1:0]   o_tdata,
    output logic                     o_tlast,
    output logic                     o_tuser
);

    logic                w_last;
    logic                w_ready;
    logic [VB_WIDTH-1:0] w_bits;

    logic                r_valid;
    logic [CB-1:0]       r_code;
    logic [CNT_W-1:0]    r_left;
    logic [VB_WIDTH-1:0] r_last_bits;
    logic                r_error;

    assign w_last  = (r_left == CNT_W'(1));
    // A new word loads as the final byte of the current one leaves.
    assign w_ready = !r_valid || (i_tready && w_last);
    assign o_ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_code      <= i_code;
            r_left      <= i_nbytes;
            r_last_bits <= i_last_bits;
            r_error     <= i_error;
        end else if (r_valid && i_tready) begin
            r_code <= r_code >> BYTE_BITS;
            r_left <= r_left - CNT_W'(1);
        end
    end

    assign w_bits   = w_last ? r_last_bits : VB_WIDTH'(BYTE_BITS);
    assign o_tvalid = r_valid;
    assign o_tdata  = OUT_TDATA_W'({w_bits, r_code[BYTE_BITS-1:0]});
    assign o_tlast  = w_last;
    assign o_tuser  = r_error;

endmodule
`default_nettype wire

>>> rtl/elias_delta_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elias_delta_encoder
// Encodes each input value as an Elias delta code sent as a byte stream.
//
// The slave channel takes one value per transaction on s_axis_tdata. The
// master channel sends the code one byte per transaction: tdata carries the
// code byte and the count of real code bits in it, tlast marks the final
// byte of a value, tuser flags a zero input (one byte, code and count zero).
// Code bits fill each byte from bit 0; the unused bits of the final byte are
// ones.
// An accepted value passes three pipeline stages and the output shift
// register before its first byte is sent on the master channel.
// Throughput is one byte per cycle while the receiver is ready; the output
// shift register sets it. A value is sent as ceil(code bits / 8) bytes,
// 1 to 6 for 32-bit values. The stages accept a new value every cycle while
// the output keeps up. When the receiver stalls, the current byte holds and
// the stages fill and then hold their data; nothing is dropped or repeated.
// Reset clears all valid flags; no transaction is pending after reset.
// ----------------------------------------------------------------------------
module elias_delta_encoder import ede_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_WIDTH-1:0]    i_s_axis_tdata,   // [31:0] value
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,   // [7:0] code_byte,
                                                          // [11:8] valid_bits
    output logic                        o_m_axis_tlast,   // last_byte
    output logic [0:0]                  o_m_axis_tuser    // [0] error
);

    localparam int W     = eff_width(VALUE_WIDTH);
    localparam int LEN_W = len_width(VALUE_WIDTH);
    localparam int LOL_W = $clog2(LEN_W);
    localparam int NB    = code_bytes(VALUE_WIDTH);
    localparam int CB    = NB * BYTE_BITS;
    localparam int CNT_W = $clog2(NB + 1);

    logic                f_valid;
    logic                f_ready;
    logic                f_zero;
    logic [LEN_W-1:0]    f_len;
    logic [LOL_W-1:0]    f_lol;
    logic [W-1:0]        f_off;

    logic                p_valid;
    logic                p_ready;
    logic [CB-1:0]       p_code;
    logic [CNT_W-1:0]    p_nbytes;
    logic [VB_WIDTH-1:0] p_last_bits;
    logic                p_error;

    ede_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_value (i_s_axis_tdata),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_zero  (f_zero),
        .o_len   (f_len),
        .o_lol   (f_lol),
        .o_off   (f_off)
    );

    ede_pack #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (f_valid),
        .o_ready     (f_ready),
        .i_zero      (f_zero),
        .i_len       (f_len),
        .i_lol       (f_lol),
        .i_off       (f_off),
        .o_valid     (p_valid),
        .i_ready     (p_ready),
        .o_code      (p_code),
        .o_nbytes    (p_nbytes),
        .o_last_bits (p_last_bits),
        .o_error     (p_error)
    );

    ede_serial #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (p_valid),
        .o_ready     (p_ready),
        .i_code      (p_code),
        .i_nbytes    (p_nbytes),
        .i_last_bits (p_last_bits),
        .i_error     (p_error),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tlast     (o_m_axis_tlast),
        .o_tuser     (o_m_axis_tuser[0])
    );

endmodule
`default_nettype wire
